// ===== rtl/cau_pkg.sv =====
// Types and constants shared by the complex arithmetic unit.
package cau_pkg;

    // Operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4
    } t_op;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Division and square root steps, one quotient or root bit each
    localparam int NSTEP = 33;

    // Input item
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_in;

    // Result item
    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic [1:0]         status;
    } t_out;

    // Narrowed part with clamp flag
    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_nar;

    // Input register stage
    typedef struct packed {
        logic valid;
        t_in  cmd;
    } t_sa;

    // Product stage
    typedef struct packed {
        logic        valid;
        logic [2:0]  op;
        logic        divz;
        logic        sat;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic [63:0] p_rr;
        logic [63:0] p_ii;
        logic [63:0] p_ri;
        logic [63:0] p_ir;
        logic [63:0] q_rr;
        logic [63:0] q_ii;
    } t_sb;

    // Sum stage, sign and magnitude
    typedef struct packed {
        logic        valid;
        logic [2:0]  op;
        logic        divz;
        logic        sat;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] mag_re;
        logic [63:0] mag_im;
        logic [63:0] den;
    } t_sc;

    // Divide and root step stage
    typedef struct packed {
        logic        valid;
        logic [2:0]  op;
        logic        divz;
        logic        sat;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        neg_re;
        logic        neg_im;
        logic        ovf_re;
        logic        ovf_im;
        logic [63:0] den;
        logic [64:0] rem_re;
        logic [64:0] rem_im;
        logic [32:0] x_re;
        logic [32:0] x_im;
        logic [32:0] q_re;
        logic [32:0] q_im;
    } t_step;

endpackage

// ===== rtl/complex_arith_unit.sv =====
// Complex arithmetic unit: pipelined add, subtract, multiply, divide and magnitude.
//
// Usage:
//   Drive i_cmd and raise i_start for one cycle per item. An item is taken at
//   each rising edge with i_start high and o_busy low; o_busy is always low,
//   so one item may enter on every clock.
//   Each result appears on o_res for exactly one cycle with o_valid high,
//   in the order the items were taken.
//   Every opcode passes the same stages: input register, products, sums,
//   divider setup, 33 restoring divide / square-root steps (one quotient or
//   root bit per stage) and the output register.
//   Throughput is one item per cycle.
//   Status: ST_OK, ST_DIVZ for a zero divisor (result zero), ST_SAT when a
//   part was clamped to the signed 32-bit range.
//   Reset (synchronous, active low) clears all valid bits; items in flight
//   are dropped and no result appears until new items arrive.
//   The receiver cannot stall: a result not taken in its cycle is gone.
module complex_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  cau_pkg::t_in    i_cmd,
    output logic            o_busy,
    output logic            o_valid,
    output cau_pkg::t_out   o_res
);

    localparam int LATENCY = cau_pkg::NSTEP + 5;

    // Narrow a sign and magnitude to 32 bits with clamping
    function automatic cau_pkg::t_nar f_narrow(input logic neg, input logic [63:0] mag);
        cau_pkg::t_nar r;
        r.sat = 1'b0;
        if (!neg) begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r.sat = 1'b1;
                r.val = 32'h7FFF_FFFF;
            end else begin
                r.val = mag[31:0];
            end
        end else begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.sat = 1'b1;
                r.val = 32'h8000_0000;
            end else begin
                r.val = ~mag[31:0] + 32'd1;
            end
        end
        return r;
    endfunction

    cau_pkg::t_sa   r_a;
    cau_pkg::t_sb   r_b, n_b;
    cau_pkg::t_sc   r_c, n_c;
    cau_pkg::t_step r_st [0:cau_pkg::NSTEP];
    cau_pkg::t_step n_st0;
    logic           r_valid;
    cau_pkg::t_out  r_res, n_res;

    logic w_accept;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    // Register the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else begin
            r_a.valid <= w_accept;
            r_a.cmd   <= i_cmd;
        end
    end

    // Products and add/subtract
    logic signed [31:0] w_ar, w_ai, w_br, w_bi, w_m0, w_m1;
    logic signed [63:0] w_rr, w_ii, w_ri, w_ir, w_qr, w_qi;
    logic [32:0]        w_bsr, w_bsi, w_sr, w_si, w_mr, w_mi;
    cau_pkg::t_nar      w_nr, w_ni;
    logic               w_sub, w_mag;

    always_comb begin
        w_ar  = r_a.cmd.a_re;
        w_ai  = r_a.cmd.a_im;
        w_br  = r_a.cmd.b_re;
        w_bi  = r_a.cmd.b_im;
        w_mag = (r_a.cmd.opcode == cau_pkg::OP_MAG);
        w_sub = (r_a.cmd.opcode == cau_pkg::OP_SUB);
        w_m0  = w_mag ? w_ar : w_br;
        w_m1  = w_mag ? w_ai : w_bi;
        w_rr  = w_ar * w_m0;
        w_ii  = w_ai * w_m1;
        w_ri  = w_ar * w_bi;
        w_ir  = w_ai * w_br;
        w_qr  = w_br * w_br;
        w_qi  = w_bi * w_bi;
        w_bsr = w_sub ? (33'd0 - {w_br[31], w_br}) : {w_br[31], w_br};
        w_bsi = w_sub ? (33'd0 - {w_bi[31], w_bi}) : {w_bi[31], w_bi};
        w_sr  = {w_ar[31], w_ar} + w_bsr;
        w_si  = {w_ai[31], w_ai} + w_bsi;
        w_mr  = w_sr[32] ? (33'd0 - w_sr) : w_sr;
        w_mi  = w_si[32] ? (33'd0 - w_si) : w_si;
        w_nr  = f_narrow(w_sr[32], {31'd0, w_mr});
        w_ni  = f_narrow(w_si[32], {31'd0, w_mi});

        n_b.valid = r_a.valid;
        n_b.op    = r_a.cmd.opcode;
        n_b.divz  = (w_br == 32'sd0) && (w_bi == 32'sd0);
        n_b.p_rr  = w_rr;
        n_b.p_ii  = w_ii;
        n_b.p_ri  = w_ri;
        n_b.p_ir  = w_ir;
        n_b.q_rr  = w_qr;
        n_b.q_ii  = w_qi;
        if (w_sub || r_a.cmd.opcode == cau_pkg::OP_ADD) begin
            n_b.res_re = w_nr.val;
            n_b.res_im = w_ni.val;
            n_b.sat    = w_nr.sat | w_ni.sat;
        end else begin
            n_b.res_re = 32'd0;
            n_b.res_im = 32'd0;
            n_b.sat    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else begin
            r_b <= n_b;
        end
    end

    // Sums of products as sign and magnitude, divisor
    logic [64:0] w_cr, w_ci, w_nre, w_nim;

    always_comb begin
        if (r_b.op == cau_pkg::OP_MUL) begin
            w_cr = {r_b.p_rr[63], r_b.p_rr} - {r_b.p_ii[63], r_b.p_ii};
            w_ci = {r_b.p_ri[63], r_b.p_ri} + {r_b.p_ir[63], r_b.p_ir};
        end else begin
            w_cr = {r_b.p_rr[63], r_b.p_rr} + {r_b.p_ii[63], r_b.p_ii};
            w_ci = {r_b.p_ir[63], r_b.p_ir} - {r_b.p_ri[63], r_b.p_ri};
        end
        w_nre = 65'd0 - w_cr;
        w_nim = 65'd0 - w_ci;

        n_c.valid  = r_b.valid;
        n_c.op     = r_b.op;
        n_c.divz   = r_b.divz;
        n_c.sat    = r_b.sat;
        n_c.res_re = r_b.res_re;
        n_c.res_im = r_b.res_im;
        n_c.neg_re = w_cr[64];
        n_c.neg_im = w_ci[64];
        n_c.mag_re = w_cr[64] ? w_nre[63:0] : w_cr[63:0];
        n_c.mag_im = w_ci[64] ? w_nim[63:0] : w_ci[63:0];
        n_c.den    = r_b.q_rr + r_b.q_ii;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else begin
            r_c <= n_c;
        end
    end

    // Narrow products, set up divider and root
    logic [95:0]   w_xr, w_xi;
    logic [64:0]   w_r0r, w_r0i;
    cau_pkg::t_nar w_pr, w_pi;

    always_comb begin
        w_xr  = {32'd0, r_c.mag_re} << FRAC_BITS;
        w_xi  = {32'd0, r_c.mag_im} << FRAC_BITS;
        w_r0r = {2'd0, w_xr[95:33]};
        w_r0i = {2'd0, w_xi[95:33]};
        w_pr  = f_narrow(r_c.neg_re, r_c.mag_re >> FRAC_BITS);
        w_pi  = f_narrow(r_c.neg_im, r_c.mag_im >> FRAC_BITS);

        n_st0.valid  = r_c.valid;
        n_st0.op     = r_c.op;
        n_st0.divz   = r_c.divz;
        n_st0.neg_re = r_c.neg_re;
        n_st0.neg_im = r_c.neg_im;
        n_st0.den    = r_c.den;
        n_st0.ovf_re = w_r0r >= {1'b0, r_c.den};
        n_st0.ovf_im = w_r0i >= {1'b0, r_c.den};
        n_st0.x_re   = w_xr[32:0];
        n_st0.x_im   = w_xi[32:0];
        n_st0.q_re   = 33'd0;
        n_st0.q_im   = 33'd0;
        n_st0.rem_im = w_r0i;
        n_st0.rem_re = (r_c.op == cau_pkg::OP_MAG) ? {1'b0, r_c.mag_re} : w_r0r;
        if (r_c.op == cau_pkg::OP_MUL) begin
            n_st0.res_re = w_pr.val;
            n_st0.res_im = w_pi.val;
            n_st0.sat    = w_pr.sat | w_pi.sat;
        end else begin
            n_st0.res_re = r_c.res_re;
            n_st0.res_im = r_c.res_im;
            n_st0.sat    = r_c.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].valid <= 1'b0;
        end else begin
            r_st[0] <= n_st0;
        end
    end

    // One quotient bit (divide) or root bit (magnitude) per stage
    for (genvar j = 1; j <= cau_pkg::NSTEP; j++) begin : g_step
        localparam int K = cau_pkg::NSTEP - j;

        cau_pkg::t_step n_step;
        logic [64:0]    w_shr, w_shi, w_trial;
        logic           w_ger, w_gei, w_get;

        always_comb begin
            n_step  = r_st[j-1];
            w_shr   = {r_st[j-1].rem_re[63:0], r_st[j-1].x_re[K]};
            w_shi   = {r_st[j-1].rem_im[63:0], r_st[j-1].x_im[K]};
            w_ger   = w_shr >= {1'b0, r_st[j-1].den};
            w_gei   = w_shi >= {1'b0, r_st[j-1].den};
            w_trial = ({32'd0, r_st[j-1].q_re} << (K + 1)) + (65'd1 << (2 * K));
            w_get   = r_st[j-1].rem_re >= w_trial;
            if (r_st[j-1].op == cau_pkg::OP_MAG) begin
                if (w_get) begin
                    n_step.rem_re  = r_st[j-1].rem_re - w_trial;
                    n_step.q_re[K] = 1'b1;
                end
            end else begin
                n_step.rem_re  = w_ger ? (w_shr - {1'b0, r_st[j-1].den}) : w_shr;
                n_step.q_re[K] = w_ger;
                n_step.rem_im  = w_gei ? (w_shi - {1'b0, r_st[j-1].den}) : w_shi;
                n_step.q_im[K] = w_gei;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[j].valid <= 1'b0;
            end else begin
                r_st[j] <= n_step;
            end
        end
    end

    // Final narrowing and status
    cau_pkg::t_step w_last;
    cau_pkg::t_nar  w_fr, w_fi;

    always_comb begin
        w_last = r_st[cau_pkg::NSTEP];
        w_fr   = f_narrow(w_last.neg_re,
                          w_last.ovf_re ? 64'h0000_0001_0000_0000 : {31'd0, w_last.q_re});
        w_fi   = f_narrow(w_last.neg_im,
                          w_last.ovf_im ? 64'h0000_0001_0000_0000 : {31'd0, w_last.q_im});
        n_res.res_re = w_last.res_re;
        n_res.res_im = w_last.res_im;
        n_res.status = w_last.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        unique case (w_last.op)
            cau_pkg::OP_DIV: begin
                if (w_last.divz) begin
                    n_res.res_re = 32'd0;
                    n_res.res_im = 32'd0;
                    n_res.status = cau_pkg::ST_DIVZ;
                end else begin
                    n_res.res_re = w_fr.val;
                    n_res.res_im = w_fi.val;
                    n_res.status = (w_fr.sat | w_fi.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::OP_MAG: begin
                w_fr         = f_narrow(1'b0, {31'd0, w_last.q_re});
                n_res.res_re = w_fr.val;
                n_res.res_im = 32'd0;
                n_res.status = w_fr.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.valid;
            r_res   <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef ASSERT_OFF
    // Every result traces back to an item taken a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result without matching item");

    // Divide by zero gives a zero result
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == cau_pkg::ST_DIVZ) |->
            (o_res.res_re == 32'sd0 && o_res.res_im == 32'sd0))
        else $error("nonzero result on divide by zero");

    // Saturation leaves a part at a clamp value
    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == cau_pkg::ST_SAT) |->
            (o_res.res_re == 32'sh7FFF_FFFF || o_res.res_re == 32'sh8000_0000 ||
             o_res.res_im == 32'sh7FFF_FFFF || o_res.res_im == 32'sh8000_0000))
        else $error("saturation status without clamped part");

    // Status is a defined code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.status == cau_pkg::ST_OK || o_res.status == cau_pkg::ST_DIVZ ||
                     o_res.status == cau_pkg::ST_SAT))
        else $error("undefined status code");
`endif

endmodule
